>>> hdl/cor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cor_pkg;

    localparam int POS_W   = 16;
    localparam int RAD_W   = 12;
    localparam int DIFF_W  = 17;
    localparam int RSUM_W  = 13;
    localparam int SQ_W    = 32;
    localparam int RR_W    = 26;
    localparam int SUM_W   = 33;
    localparam int RADB_W  = 34;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 35;
    localparam int SQRT_STEPS = 32;
    localparam int GUARD   = 15;
    localparam int GAP_W   = 28;
    localparam int MAG_W   = 16;
    localparam int PROD_W  = 44;
    localparam int NUM_W   = 45;
    localparam int DEN_W   = 33;
    localparam int Q_W     = 13;
    localparam int EXT_W   = 18;

    typedef struct packed {
        logic signed [POS_W-1:0]  ax;
        logic signed [POS_W-1:0]  ay;
        logic signed [POS_W-1:0]  bx;
        logic signed [POS_W-1:0]  by;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [RSUM_W-1:0]        rsum;
        logic [SUM_W-1:0]         s;
        logic                     over;
        logic                     coin;
    } cor_entry_t;

    typedef struct packed {
        cor_entry_t        ent;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RADB_W-1:0] rad;
    } cor_sq_t;

    typedef struct packed {
        cor_entry_t        ent;
        logic [ROOT_W-1:0] len;
        logic [PROD_W-1:0] prod_x;
        logic [PROD_W-1:0] prod_y;
    } cor_mul_t;

    typedef struct packed {
        cor_entry_t       ent;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
    } cor_div_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic                    overlapping;
        logic                    coincident;
    } cor_res_t;

    // One digit of the square root: two radicand bits in, one root bit out.
    function automatic cor_sq_t sqrt_step(input cor_sq_t s);
        cor_sq_t          r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        r      = s;
        rem_sh = {s.rem[REM_W-3:0], s.rad[RADB_W-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        r.rad = {s.rad[RADB_W-3:0], 2'b00};
        return r;
    endfunction

    // One quotient bit for each of two restoring divisions by one divisor, for a fixed bit position.
    function automatic cor_div_t div_step(input cor_div_t d, input int b);
        cor_div_t         r;
        logic [NUM_W:0]   trial;
        logic [NUM_W:0]   nx;
        logic [NUM_W:0]   ny;
        r     = d;
        trial = {{(NUM_W + 1 - DEN_W){1'b0}}, d.den} << b;
        nx    = {1'b0, d.num_x};
        ny    = {1'b0, d.num_y};
        if (nx >= trial)
        begin
            nx      = nx - trial;
            r.q_x   = d.q_x | (Q_W'(1) << b);
        end
        if (ny >= trial)
        begin
            ny      = ny - trial;
            r.q_y   = d.q_y | (Q_W'(1) << b);
        end
        r.num_x = nx[NUM_W-1:0];
        r.num_y = ny[NUM_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > EXT_W'(signed'(32767)))
            r = 16'sh7fff;
        else if (v < -EXT_W'(signed'(32768)))
            r = -16'sh8000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cor_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cor_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [cor_pkg::POS_W-1:0] a_x,
    input  wire logic signed [cor_pkg::POS_W-1:0] a_y,
    input  wire logic [cor_pkg::RAD_W-1:0]     a_radius,
    input  wire logic signed [cor_pkg::POS_W-1:0] b_x,
    input  wire logic signed [cor_pkg::POS_W-1:0] b_y,
    input  wire logic [cor_pkg::RAD_W-1:0]     b_radius,
    output cor_pkg::cor_entry_t                ent,
    output logic                               ent_valid,
    input  wire logic                          ent_ready
);
    import cor_pkg::*;

    logic adv;
    logic s1_v_reg, s2_v_reg, s3_v_reg;

    logic signed [POS_W-1:0]  ax_reg [3];
    logic signed [POS_W-1:0]  ay_reg [3];
    logic signed [POS_W-1:0]  bx_reg [3];
    logic signed [POS_W-1:0]  by_reg [3];
    logic signed [DIFF_W-1:0] dx_reg [3];
    logic signed [DIFF_W-1:0] dy_reg [3];
    logic [RSUM_W-1:0]        rsum_reg [3];

    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [RR_W-1:0] rr_reg;
    logic [SUM_W-1:0] s_reg;
    logic over_reg, coin_reg;

    logic signed [2*DIFF_W-1:0] px, py;
    logic [SUM_W-1:0] s_next;

    assign adv  = !s3_v_reg || ent_ready;
    assign full = !adv;

    assign px     = dx_reg[0] * dx_reg[0];
    assign py     = dy_reg[0] * dy_reg[0];
    assign s_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= push;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg[0]   <= a_x;
            ay_reg[0]   <= a_y;
            bx_reg[0]   <= b_x;
            by_reg[0]   <= b_y;
            dx_reg[0]   <= DIFF_W'(a_x) - DIFF_W'(b_x);
            dy_reg[0]   <= DIFF_W'(a_y) - DIFF_W'(b_y);
            rsum_reg[0] <= {1'b0, a_radius} + {1'b0, b_radius};
            for (int i = 1; i < 3; i++)
            begin
                ax_reg[i]   <= ax_reg[i-1];
                ay_reg[i]   <= ay_reg[i-1];
                bx_reg[i]   <= bx_reg[i-1];
                by_reg[i]   <= by_reg[i-1];
                dx_reg[i]   <= dx_reg[i-1];
                dy_reg[i]   <= dy_reg[i-1];
                rsum_reg[i] <= rsum_reg[i-1];
            end
            sqx_reg  <= px[SQ_W-1:0];
            sqy_reg  <= py[SQ_W-1:0];
            rr_reg   <= rsum_reg[0] * rsum_reg[0];
            s_reg    <= s_next;
            over_reg <= {{(SUM_W - RR_W){1'b0}}, rr_reg} > s_next;
            coin_reg <= (s_next == '0);
        end
    end

    always_comb
    begin
        ent.ax   = ax_reg[2];
        ent.ay   = ay_reg[2];
        ent.bx   = bx_reg[2];
        ent.by   = by_reg[2];
        ent.dx   = dx_reg[2];
        ent.dy   = dy_reg[2];
        ent.rsum = rsum_reg[2];
        ent.s    = s_reg;
        ent.over = over_reg;
        ent.coin = coin_reg;
    end

    assign ent_valid = s3_v_reg;

endmodule

`default_nettype wire

>>> hdl/cor_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cor_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              ready,
    input  wire cor_pkg::cor_entry_t in_ent,
    output cor_pkg::cor_entry_t out_ent,
    output logic              avail,
    input  wire logic         pop
);
    import cor_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cor_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && avail;
    assign out_ent = mem[head_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[tail_reg] <= in_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                tail_reg <= (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            if (do_pop)
                head_reg <= (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into a full queue");

endmodule

`default_nettype wire

>>> hdl/cor_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cor_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cor_pkg::cor_entry_t q_ent,
    input  wire logic          q_avail,
    output logic               q_pop,
    output logic               empty,
    input  wire logic          pop,
    output cor_pkg::cor_res_t  res
);
    import cor_pkg::*;

    cor_sq_t  sq_reg [SQRT_STEPS + 1];
    logic     sv_reg [SQRT_STEPS + 1];
    cor_mul_t mul_reg;
    logic     mv_reg;
    cor_div_t dv_reg [Q_W + 1];
    logic     dvv_reg [Q_W + 1];
    cor_res_t out_reg;
    logic     out_v_reg;
    logic     adv;

    cor_sq_t            sq_in;
    logic [ROOT_W-1:0]  len;
    logic [GAP_W-1:0]   gap;
    logic [MAG_W-1:0]   mag_x, mag_y;
    logic signed [DIFF_W-1:0] neg_x, neg_y;
    cor_div_t           num_in;
    cor_res_t           res_next;
    cor_entry_t         fe;
    logic signed [EXT_W-1:0] qx, qy, ax, ay, bx, by;

    assign adv   = !out_v_reg || pop;
    assign q_pop = adv && q_avail;
    assign empty = !out_v_reg;
    assign res   = out_reg;

    always_comb
    begin
        sq_in.ent  = q_ent;
        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.rad  = {1'b0, q_ent.s};
    end

    assign len   = sq_reg[SQRT_STEPS].root;
    assign gap   = {sq_reg[SQRT_STEPS].ent.rsum, {GUARD{1'b0}}} - len[GAP_W-1:0];
    assign neg_x = -sq_reg[SQRT_STEPS].ent.dx;
    assign neg_y = -sq_reg[SQRT_STEPS].ent.dy;
    assign mag_x = sq_reg[SQRT_STEPS].ent.dx[DIFF_W-1] ? neg_x[MAG_W-1:0]
                                                       : sq_reg[SQRT_STEPS].ent.dx[MAG_W-1:0];
    assign mag_y = sq_reg[SQRT_STEPS].ent.dy[DIFF_W-1] ? neg_y[MAG_W-1:0]
                                                       : sq_reg[SQRT_STEPS].ent.dy[MAG_W-1:0];

    always_comb
    begin
        num_in.ent   = mul_reg.ent;
        num_in.num_x = {1'b0, mul_reg.prod_x} + NUM_W'(mul_reg.len);
        num_in.num_y = {1'b0, mul_reg.prod_y} + NUM_W'(mul_reg.len);
        num_in.den   = {mul_reg.len, 1'b0};
        num_in.q_x   = '0;
        num_in.q_y   = '0;
    end

    // Over and not coin: apply signed shift, B opposite to A, saturate.
    always_comb
    begin
        fe = dv_reg[Q_W].ent;
        qx = EXT_W'(dv_reg[Q_W].q_x);
        qy = EXT_W'(dv_reg[Q_W].q_y);
        ax = EXT_W'($signed(fe.ax));
        ay = EXT_W'($signed(fe.ay));
        bx = EXT_W'($signed(fe.bx));
        by = EXT_W'($signed(fe.by));
        if (fe.dx[DIFF_W-1])
            qx = -qx;
        if (fe.dy[DIFF_W-1])
            qy = -qy;
        res_next.overlapping = fe.over;
        res_next.coincident  = fe.coin;
        if (fe.over && !fe.coin)
        begin
            res_next.new_a_x = sat16(ax + qx);
            res_next.new_a_y = sat16(ay + qy);
            res_next.new_b_x = sat16(bx - qx);
            res_next.new_b_y = sat16(by - qy);
        end
        else
        begin
            res_next.new_a_x = fe.ax;
            res_next.new_a_y = fe.ay;
            res_next.new_b_x = fe.bx;
            res_next.new_b_y = fe.by;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQRT_STEPS; i++)
                sv_reg[i] <= 1'b0;
            for (int i = 0; i <= Q_W; i++)
                dvv_reg[i] <= 1'b0;
            mv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= q_avail;
            for (int i = 1; i <= SQRT_STEPS; i++)
                sv_reg[i] <= sv_reg[i-1];
            mv_reg     <= sv_reg[SQRT_STEPS];
            dvv_reg[0] <= mv_reg;
            for (int i = 1; i <= Q_W; i++)
                dvv_reg[i] <= dvv_reg[i-1];
            out_v_reg <= dvv_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_in;
            for (int i = 1; i <= SQRT_STEPS; i++)
                sq_reg[i] <= sqrt_step(sq_reg[i-1]);
            mul_reg.ent    <= sq_reg[SQRT_STEPS].ent;
            mul_reg.len    <= len;
            mul_reg.prod_x <= mag_x * gap;
            mul_reg.prod_y <= mag_y * gap;
            dv_reg[0] <= num_in;
            for (int i = 1; i <= Q_W; i++)
                dv_reg[i] <= div_step(dv_reg[i-1], Q_W - i);
            out_reg <= res_next;
        end
    end

    a_result_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        (dvv_reg[Q_W] && adv) |=> out_v_reg)
        else $error("finished item did not reach the result register");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |=> (out_v_reg && $stable(out_reg)))
        else $error("waiting result changed or vanished");

endmodule

`default_nettype wire

>>> hdl/circle_overlap_resolve.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake      Payload
// -------   ------------   ---------------------------------------------------
// input     push / full    a_x, a_y, a_radius, b_x, b_y, b_radius
// result    pop / empty    new_a_x, new_a_y, new_b_x, new_b_y, overlapping,
//                          coincident
//
// One item enters per cycle while full is low; one result leaves per cycle with pop held, empty low.
// Items pass through the front, the queue and the back in that order; the
// 32-step square root pipeline and the 13-step divider set the back length.
// Reset is asynchronous and empties every stage; no clearing pass follows it.
// A result not popped stalls the back pipeline, the queue absorbs the front, and
// full rises once both are stopped.

module circle_overlap_resolve #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [cor_pkg::POS_W-1:0]  a_x,
    input  wire logic signed [cor_pkg::POS_W-1:0]  a_y,
    input  wire logic [cor_pkg::RAD_W-1:0]         a_radius,
    input  wire logic signed [cor_pkg::POS_W-1:0]  b_x,
    input  wire logic signed [cor_pkg::POS_W-1:0]  b_y,
    input  wire logic [cor_pkg::RAD_W-1:0]         b_radius,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [cor_pkg::POS_W-1:0]       new_a_x,
    output logic signed [cor_pkg::POS_W-1:0]       new_a_y,
    output logic signed [cor_pkg::POS_W-1:0]       new_b_x,
    output logic signed [cor_pkg::POS_W-1:0]       new_b_y,
    output logic                                   overlapping,
    output logic                                   coincident
);
    import cor_pkg::*;

    cor_entry_t f_ent, q_ent;
    logic       f_valid, q_ready, q_avail, q_pop;
    cor_res_t   res;

    // The front computes the differences, squared distance, overlap and coincidence tests.
    cor_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_radius  (a_radius),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_radius  (b_radius),
        .ent       (f_ent),
        .ent_valid (f_valid),
        .ent_ready (q_ready)
    );

    // The queue lets the front keep taking items while the back is stalled.
    cor_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_valid && q_ready),
        .ready   (q_ready),
        .in_ent  (f_ent),
        .out_ent (q_ent),
        .avail   (q_avail),
        .pop     (q_pop)
    );

    // The back takes the square root, divides out the shift and saturates.
    cor_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_ent   (q_ent),
        .q_avail (q_avail),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign new_a_x     = res.new_a_x;
    assign new_a_y     = res.new_a_y;
    assign new_b_x     = res.new_b_x;
    assign new_b_y     = res.new_b_y;
    assign overlapping = res.overlapping;
    assign coincident  = res.coincident;

endmodule

`default_nettype wire

>>> dv/tb_circle_overlap_resolve.sv
`timescale 1ns / 1ps

module tb_circle_overlap_resolve;

    import cor_pkg::*;

    // One pair of circles as offered on the input side.
    typedef struct {
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic [RAD_W-1:0]        ar;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic [RAD_W-1:0]        br;
    } pair_t;

    // A row of the directed table. When has_res is set, the typed-in result is
    // checked against the predictor so a predictor slip cannot hide a bug.
    typedef struct {
        pair_t    p;
        bit       has_res;
        cor_res_t r;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic signed [POS_W-1:0] a_x;
    logic signed [POS_W-1:0] a_y;
    logic [RAD_W-1:0]        a_radius;
    logic signed [POS_W-1:0] b_x;
    logic signed [POS_W-1:0] b_y;
    logic [RAD_W-1:0]        b_radius;
    logic                    empty;
    logic                    pop;
    logic signed [POS_W-1:0] new_a_x;
    logic signed [POS_W-1:0] new_a_y;
    logic signed [POS_W-1:0] new_b_x;
    logic signed [POS_W-1:0] new_b_y;
    logic                    overlapping;
    logic                    coincident;

    cor_res_t corrected_q[$];
    int       n_fail;
    int       n_results;
    int       n_over;
    int       n_coin;
    bit       stim_done;
    bit       hold_off;
    row_t     dir_rows[$];

    circle_overlap_resolve u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_x(a_x), .a_y(a_y), .a_radius(a_radius),
        .b_x(b_x), .b_y(b_y), .b_radius(b_radius),
        .empty(empty), .pop(pop),
        .new_a_x(new_a_x), .new_a_y(new_a_y), .new_b_x(new_b_x), .new_b_y(new_b_y),
        .overlapping(overlapping), .coincident(coincident)
    );

    always #1 clk = ~clk;

    // Integer square root by the bit-pair method, on the 63-bit scaled
    // squared distance.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return -16'sh8000;
        return v[POS_W-1:0];
    endfunction

    // Half of the overlap projected on one axis, rounded half away from zero.
    function automatic longint axis_push(input longint d, input longint unsigned gap,
                                         input longint unsigned len);
        longint unsigned mag;
        longint unsigned m;
        mag = (d < 0) ? -d : d;
        m   = (mag * gap + len) / (2 * len);
        return (d < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic cor_res_t resolve_pair(input pair_t p);
        cor_res_t        r;
        longint          dx;
        longint          dy;
        longint unsigned s;
        longint unsigned rs;
        longint unsigned len;
        longint unsigned gap;
        longint          sx;
        longint          sy;
        dx = longint'(p.ax) - longint'(p.bx);
        dy = longint'(p.ay) - longint'(p.by);
        s  = dx * dx + dy * dy;
        rs = longint'(p.ar) + longint'(p.br);
        r.overlapping = (rs * rs > s);
        r.coincident  = (s == 0);
        sx = 0;
        sy = 0;
        if (r.overlapping && !r.coincident)
        begin
            len = int_sqrt(s << (2 * GUARD));
            gap = (rs << GUARD) - len;
            sx  = axis_push(dx, gap, len);
            sy  = axis_push(dy, gap, len);
        end
        r.new_a_x = clamp16(longint'(p.ax) + sx);
        r.new_a_y = clamp16(longint'(p.ay) + sy);
        r.new_b_x = clamp16(longint'(p.bx) - sx);
        r.new_b_y = clamp16(longint'(p.by) - sy);
        return r;
    endfunction

    function automatic pair_t mk_pair(input int ax, input int ay, input int ar,
                                      input int bx, input int by, input int br);
        pair_t p;
        p.ax = ax; p.ay = ay; p.ar = ar; p.bx = bx; p.by = by; p.br = br;
        return p;
    endfunction

    function automatic cor_res_t mk_res(input int nax, input int nay, input int nbx,
                                        input int nby, input bit ov, input bit co);
        cor_res_t r;
        r.new_a_x = nax; r.new_a_y = nay; r.new_b_x = nbx; r.new_b_y = nby;
        r.overlapping = ov; r.coincident = co;
        return r;
    endfunction

    task automatic add_row(input pair_t p, input bit has_res, input cor_res_t r);
        row_t w;
        w.p = p; w.has_res = has_res; w.r = r;
        dir_rows.push_back(w);
    endtask

    // Random pair. Most pairs are close together with radii that often touch, so the
    // correction path is exercised; the rest are coincident, near the rails or full range.
    function automatic pair_t rand_pair();
        pair_t p;
        int    mode;
        int    span;
        mode = $urandom_range(0, 9);
        p.ax = $urandom;
        p.ay = $urandom;
        p.ar = $urandom;
        p.br = $urandom;
        if (mode < 6)
        begin
            span = (mode < 3) ? 64 : 8192;
            p.bx = clamp16(longint'(p.ax) + $signed($urandom_range(0, 2 * span)) - span);
            p.by = clamp16(longint'(p.ay) + $signed($urandom_range(0, 2 * span)) - span);
            if (mode < 3)
            begin
                p.ar = $urandom_range(0, 80);
                p.br = $urandom_range(0, 80);
            end
        end
        else if (mode == 6)
        begin
            // Coincident centres.
            p.bx = p.ax;
            p.by = p.ay;
        end
        else if (mode == 7)
        begin
            // Pairs pinned near the rails so the pushed centres saturate.
            p.ax = ($urandom_range(0, 1) != 0) ? 16'sh7ff0 : -16'sh7ff0;
            p.bx = p.ax - $signed($urandom_range(0, 64)) + 32;
            p.by = p.ay + $signed($urandom_range(0, 64)) - 32;
        end
        else
        begin
            p.bx = $urandom;
            p.by = $urandom;
        end
        return p;
    endfunction

    // push stays high from one item to the next when no idle cycles are drawn.
    task automatic send_pair(input pair_t p);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        a_x      <= p.ax;
        a_y      <= p.ay;
        a_radius <= p.ar;
        b_x      <= p.bx;
        b_y      <= p.by;
        b_radius <= p.br;
        corrected_q.push_back(resolve_pair(p));
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Sender: directed table, then random pairs.
    initial
    begin
        int       i;
        cor_res_t pred;
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        a_x       = '0;
        a_y       = '0;
        a_radius  = '0;
        b_x       = '0;
        b_y       = '0;
        b_radius  = '0;
        n_fail    = 0;
        stim_done = 1'b0;

        // All-zero pair is coincident and, with no radius, not overlapping.
        add_row(mk_pair(0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 1));
        // Coincident with radius: overlap flagged but no correction applied.
        add_row(mk_pair(100, -200, 4095, 100, -200, 4095), 1,
                mk_res(100, -200, 100, -200, 1, 1));
        add_row(mk_pair(-32768, 32767, 1, -32768, 32767, 0), 1,
                mk_res(-32768, 32767, -32768, 32767, 1, 1));
        // Far apart, no overlap: centres pass through.
        add_row(mk_pair(-32768, -32768, 4095, 32767, 32767, 4095), 1,
                mk_res(-32768, -32768, 32767, 32767, 0, 0));
        add_row(mk_pair(32767, 0, 0, -32768, 0, 0), 1,
                mk_res(32767, 0, -32768, 0, 0, 0));
        // Touching exactly is not an overlap.
        add_row(mk_pair(0, 0, 16, 32, 0, 16), 1, mk_res(0, 0, 32, 0, 0, 0));
        add_row(mk_pair(0, 0, 30, 30, 40, 20), 1, mk_res(0, 0, 30, 40, 0, 0));
        // Along x and along y: distance 32, radius sum 48, each moves 8 outward.
        add_row(mk_pair(0, 0, 24, 32, 0, 24), 1, mk_res(-8, 0, 40, 0, 1, 0));
        add_row(mk_pair(0, 0, 24, 0, -32, 24), 1, mk_res(0, 8, 0, -40, 1, 0));
        // Saturation against both rails. Half of 8183 rounds away from zero.
        add_row(mk_pair(32767, 0, 4095, 32760, 0, 4095), 1,
                mk_res(32767, 0, 32760 - 4092, 0, 1, 0));
        add_row(mk_pair(-32768, 0, 4095, -32760, 0, 4095), 1,
                mk_res(-32768, 0, -32760 + 4091, 0, 1, 0));
        // Diagonal and near-touching rows, checked by the predictor only.
        add_row(mk_pair(10, 10, 20, 20, 20, 20), 0, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(-5, 7, 4095, 3, -9, 0), 0, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(0, 0, 2047, 2894, 2894, 2048), 0, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(1, 0, 1, 0, 0, 1), 0, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(-1, -1, 3, 0, 0, 0), 0, mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(32767, 32767, 4095, -32768, -32768, 4095), 0,
                mk_res(0, 0, 0, 0, 0, 0));
        add_row(mk_pair(12345, -23456, 2730, 9876, -21000, 1365), 0,
                mk_res(0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].has_res)
            begin
                pred = resolve_pair(dir_rows[k].p);
                if (pred != dir_rows[k].r)
                begin
                    $error("directed row %0d: table result disagrees with predictor", k);
                    n_fail++;
                end
            end
            send_pair(dir_rows[k].p);
        end

        for (i = 0; i < 600; i++)
        begin
            // Partway through, the receiver holds off so the block fills up.
            if (i == 200)
                hold_off = 1'b1;
            send_pair(rand_pair());
        end
        push      <= 1'b0;
        stim_done = 1'b1;
    end

    // Long receiver hold-off, counted here while the sender keeps pushing.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_off);
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    // Receiver: random pop gaps, checks each accepted result. pop stays high
    // from one result to the next when no idle cycles are drawn.
    initial
    begin
        int       gap;
        cor_res_t want;
        pop       = 1'b0;
        n_results = 0;
        n_over    = 0;
        n_coin    = 0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0 || hold_off)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            n_results++;
            if (corrected_q.size() == 0)
            begin
                $error("result with no pair outstanding");
                n_fail++;
            end
            else
            begin
                want = corrected_q.pop_front();
                n_over += overlapping;
                n_coin += coincident;
                if (new_a_x !== want.new_a_x)
                begin
                    $error("new_a_x: expected %0d, got %0d", want.new_a_x, new_a_x);
                    n_fail++;
                end
                if (new_a_y !== want.new_a_y)
                begin
                    $error("new_a_y: expected %0d, got %0d", want.new_a_y, new_a_y);
                    n_fail++;
                end
                if (new_b_x !== want.new_b_x)
                begin
                    $error("new_b_x: expected %0d, got %0d", want.new_b_x, new_b_x);
                    n_fail++;
                end
                if (new_b_y !== want.new_b_y)
                begin
                    $error("new_b_y: expected %0d, got %0d", want.new_b_y, new_b_y);
                    n_fail++;
                end
                if (overlapping !== want.overlapping)
                begin
                    $error("overlapping: expected %0d, got %0d",
                           want.overlapping, overlapping);
                    n_fail++;
                end
                if (coincident !== want.coincident)
                begin
                    $error("coincident: expected %0d, got %0d",
                           want.coincident, coincident);
                    n_fail++;
                end
            end
        end
    end

    // End of run: drain, then give the pipeline time to show any stray result.
    initial
    begin
        wait (stim_done);
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d pair results, %0d overlapping and %0d coincident,",
                 n_results, n_over, n_coin);
        $display("including directed edge cases and a long output stall.");
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timeout waiting for results.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
